// File: hdl/bbs_pkg.sv
`timescale 1ns / 1ps

package bbs_pkg;

    localparam int unsigned LINE_BITS        = 20;
    localparam int unsigned COLUMN_BITS      = 16;
    localparam int unsigned MAX_NESTING_DEF  = 255;
    localparam int unsigned QUEUE_DEPTH_DEF  = 4;

    localparam int unsigned IN_DATA_BITS  = 8;
    localparam int unsigned OUT_DATA_BITS = 40;

    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [COLUMN_BITS-1:0] column_t;

    // lexical mode of the scanner, one-hot
    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_LINE   = 4'b0010,
        MODE_BLOCK  = 4'b0100,
        MODE_QUOTE  = 4'b1000
    } mode_t;

    typedef enum logic [2:0] {
        ST_SAFE       = 3'd0,
        ST_OPEN_QUOTE = 3'd1,
        ST_SHARED     = 3'd2,
        ST_OPEN_CMT   = 3'd3,
        ST_OPEN_BRACE = 3'd4,
        ST_TOO_DEEP   = 3'd5
    } status_t;

    localparam logic KIND_REPAIR = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // what one input item leaves for the output side: a repair, a status, or both
    typedef struct packed {
        logic    rep_valid;
        line_t   rep_line;
        column_t rep_column;
        logic    stat_valid;
        status_t stat_code;
    } rec_t;

endpackage

// File: hdl/bbs_scan.sv
`timescale 1ns / 1ps

module bbs_scan #(
    parameter int unsigned MAX_NESTING = bbs_pkg::MAX_NESTING_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         take,
    input  logic [7:0]   data_byte,
    input  logic         byte_present,
    input  logic         end_of_payload,
    output logic         push,
    output bbs_pkg::rec_t rec
);

    localparam int unsigned DW = $clog2(MAX_NESTING + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NESTING);
    localparam bbs_pkg::line_t   LINE_SAT = '1;
    localparam bbs_pkg::column_t COL_SAT  = '1;

    bbs_pkg::mode_t   mode_reg, mode_next;
    logic             qsingle_reg, qsingle_next;
    logic             esc_reg, esc_next;
    logic             star_reg, star_next;
    logic             slash_reg, slash_next;
    logic [DW-1:0]    depth_reg, depth_next;
    bbs_pkg::line_t   line_reg, line_next;
    bbs_pkg::column_t col_reg, col_next;
    logic             blank_reg, blank_next;
    logic             bp_reg, bp_next;
    logic             ps_reg, ps_next;
    bbs_pkg::column_t pcol_reg, pcol_next;
    bbs_pkg::status_t err_reg, err_next;

    logic             rep;
    logic             hspace;
    logic             blank_before;
    logic             done;
    bbs_pkg::column_t col_inc;

    assign hspace  = (data_byte == bbs_pkg::CH_SPACE) || (data_byte == bbs_pkg::CH_TAB) ||
                     (data_byte == bbs_pkg::CH_CR);
    assign col_inc = (col_reg != COL_SAT) ? col_reg + 1'b1 : col_reg;

    always_comb begin
        mode_next    = mode_reg;
        qsingle_next = qsingle_reg;
        esc_next     = esc_reg;
        star_next    = star_reg;
        slash_next   = slash_reg;
        depth_next   = depth_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        blank_next   = blank_reg;
        bp_next      = bp_reg;
        ps_next      = ps_reg;
        pcol_next    = pcol_reg;
        err_next     = err_reg;
        rep          = 1'b0;
        blank_before = blank_reg;
        done         = 1'b0;

        if (byte_present && err_reg == bbs_pkg::ST_SAFE) begin
            if (bp_reg && ps_reg) begin
                if (data_byte == bbs_pkg::CH_SLASH) begin
                    rep        = 1'b1;
                    bp_next    = 1'b0;
                    ps_next    = 1'b0;
                    mode_next  = bbs_pkg::MODE_LINE;
                    blank_next = 1'b0;
                    col_next   = col_inc;
                end else begin
                    err_next = bbs_pkg::ST_SHARED;
                end
            end else if (bp_reg && data_byte == bbs_pkg::CH_SLASH) begin
                ps_next    = 1'b1;
                blank_next = 1'b0;
                col_next   = col_inc;
            end else if (bp_reg && data_byte != bbs_pkg::CH_LF) begin
                if (hspace) col_next = col_inc;
                else        err_next = bbs_pkg::ST_SHARED;
            end else if (data_byte == bbs_pkg::CH_LF) begin
                // newline, confirming a held brace first
                if (bp_reg) begin
                    rep     = 1'b1;
                    bp_next = 1'b0;
                    ps_next = 1'b0;
                end
                line_next  = (line_reg != LINE_SAT) ? line_reg + 1'b1 : line_reg;
                col_next   = '0;
                blank_next = 1'b1;
                slash_next = 1'b0;
                star_next  = 1'b0;
                esc_next   = 1'b0;
                if (mode_reg == bbs_pkg::MODE_QUOTE) err_next  = bbs_pkg::ST_OPEN_QUOTE;
                else if (mode_reg == bbs_pkg::MODE_LINE) mode_next = bbs_pkg::MODE_NORMAL;
            end else begin
                col_next = col_inc;
                if (!hspace) blank_next = 1'b0;
                case (mode_reg)
                    bbs_pkg::MODE_LINE: begin
                    end
                    bbs_pkg::MODE_BLOCK: begin
                        if (star_reg && data_byte == bbs_pkg::CH_SLASH) begin
                            mode_next = bbs_pkg::MODE_NORMAL;
                            star_next = 1'b0;
                        end else begin
                            star_next = (data_byte == bbs_pkg::CH_STAR);
                        end
                    end
                    bbs_pkg::MODE_QUOTE: begin
                        if (esc_reg) esc_next = 1'b0;
                        else if (data_byte == bbs_pkg::CH_BSLASH) esc_next = 1'b1;
                        else if (data_byte == (qsingle_reg ? bbs_pkg::CH_SQUOTE
                                                           : bbs_pkg::CH_DQUOTE))
                            mode_next = bbs_pkg::MODE_NORMAL;
                    end
                    default: begin
                        if (slash_reg) begin
                            slash_next = 1'b0;
                            if (data_byte == bbs_pkg::CH_SLASH) begin
                                mode_next = bbs_pkg::MODE_LINE;
                                done      = 1'b1;
                            end else if (data_byte == bbs_pkg::CH_STAR) begin
                                mode_next = bbs_pkg::MODE_BLOCK;
                                star_next = 1'b0;
                                done      = 1'b1;
                            end
                        end
                        if (!done) begin
                            if (data_byte == bbs_pkg::CH_SLASH) begin
                                slash_next = 1'b1;
                            end else if (data_byte == bbs_pkg::CH_DQUOTE ||
                                         data_byte == bbs_pkg::CH_SQUOTE) begin
                                mode_next    = bbs_pkg::MODE_QUOTE;
                                qsingle_next = (data_byte == bbs_pkg::CH_SQUOTE);
                                esc_next     = 1'b0;
                            end else if (data_byte == bbs_pkg::CH_LBRACE) begin
                                if (depth_reg >= DEPTH_MAX) err_next = bbs_pkg::ST_TOO_DEEP;
                                else depth_next = depth_reg + 1'b1;
                            end else if (data_byte == bbs_pkg::CH_RBRACE) begin
                                if (depth_reg != '0) begin
                                    depth_next = depth_reg - 1'b1;
                                end else if (!blank_before) begin
                                    err_next = bbs_pkg::ST_SHARED;
                                end else begin
                                    bp_next   = 1'b1;
                                    ps_next   = 1'b0;
                                    pcol_next = col_inc;
                                end
                            end
                        end
                    end
                endcase
            end
        end

        if (end_of_payload) begin
            if (err_next == bbs_pkg::ST_SAFE && bp_next) begin
                if (ps_next) err_next = bbs_pkg::ST_SHARED;
                else         rep      = 1'b1;
            end
            if (err_next == bbs_pkg::ST_SAFE) begin
                if (mode_next == bbs_pkg::MODE_BLOCK)      err_next = bbs_pkg::ST_OPEN_CMT;
                else if (mode_next == bbs_pkg::MODE_QUOTE) err_next = bbs_pkg::ST_OPEN_QUOTE;
                else if (depth_next != '0)                 err_next = bbs_pkg::ST_OPEN_BRACE;
            end
        end
    end

    // the held brace sits on the current line; take its column from the next
    // value so that a brace arriving on the closing beat reports its own column
    always_comb begin
        rec.rep_valid  = rep;
        rec.rep_line   = line_reg;
        rec.rep_column = pcol_next;
        rec.stat_valid = end_of_payload;
        rec.stat_code  = err_next;
    end

    assign push = take && (rep || end_of_payload);

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && end_of_payload)) begin
            mode_reg    <= bbs_pkg::MODE_NORMAL;
            qsingle_reg <= 1'b0;
            esc_reg     <= 1'b0;
            star_reg    <= 1'b0;
            slash_reg   <= 1'b0;
            depth_reg   <= '0;
            line_reg    <= bbs_pkg::line_t'(1);
            col_reg     <= '0;
            blank_reg   <= 1'b1;
            bp_reg      <= 1'b0;
            ps_reg      <= 1'b0;
            pcol_reg    <= '0;
            err_reg     <= bbs_pkg::ST_SAFE;
        end else if (take) begin
            mode_reg    <= mode_next;
            qsingle_reg <= qsingle_next;
            esc_reg     <= esc_next;
            star_reg    <= star_next;
            slash_reg   <= slash_next;
            depth_reg   <= depth_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            blank_reg   <= blank_next;
            bp_reg      <= bp_next;
            ps_reg      <= ps_next;
            pcol_reg    <= pcol_next;
            err_reg     <= err_next;
        end
    end

    a_pend_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        bp_reg |-> mode_reg == bbs_pkg::MODE_NORMAL) else $error("brace held outside text");
    a_slash_needs_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        ps_reg |-> bp_reg) else $error("slash flag without held brace");

endmodule

// File: hdl/bbs_queue.sv
`timescale 1ns / 1ps

module bbs_queue #(
    parameter int unsigned DEPTH = bbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bbs_pkg::rec_t wr_rec,
    input  logic          pop,
    output bbs_pkg::rec_t rd_rec,
    output logic          full,
    output logic          empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bbs_pkg::rec_t      slot_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW:0]        count_reg, count_next;

    assign full   = (count_reg == (AW+1)'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_rec = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue underflow");

endmodule

// File: hdl/bbs_emit.sv
`timescale 1ns / 1ps

module bbs_emit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bbs_pkg::rec_t                      head,
    input  logic                               empty,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bbs_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    logic             valid_reg;
    logic             kind_reg, kind_next;
    logic             last_reg, last_next;
    bbs_pkg::line_t   line_reg, line_next;
    bbs_pkg::column_t col_reg, col_next;
    bbs_pkg::status_t stat_reg, stat_next;
    logic             sent_rep_reg, sent_rep_next;
    logic             load;
    logic             send_rep;

    assign load     = !valid_reg || m_tready;
    assign send_rep = head.rep_valid && !sent_rep_reg;

    always_comb begin
        sent_rep_next = sent_rep_reg;
        pop           = 1'b0;
        if (send_rep) begin
            kind_next = bbs_pkg::KIND_REPAIR;
            last_next = !head.stat_valid;
            line_next = head.rep_line;
            col_next  = head.rep_column;
            stat_next = bbs_pkg::ST_SAFE;
        end else begin
            kind_next = bbs_pkg::KIND_STATUS;
            last_next = 1'b1;
            line_next = '0;
            col_next  = '0;
            stat_next = head.stat_code;
        end
        if (load && !empty) begin
            // a record with both a repair and a status takes two beats
            if (send_rep && head.stat_valid) begin
                sent_rep_next = 1'b1;
            end else begin
                sent_rep_next = 1'b0;
                pop           = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            sent_rep_reg <= 1'b0;
        end else if (load) begin
            valid_reg    <= !empty;
            sent_rep_reg <= sent_rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            kind_reg <= kind_next;
            last_reg <= last_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            stat_reg <= stat_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = bbs_pkg::OUT_DATA_BITS'({stat_reg, col_reg, line_reg});

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && kind_reg == bbs_pkg::KIND_STATUS |-> last_reg)
        else $error("status beat not marked last");
    a_split_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        sent_rep_reg |-> !empty) else $error("half-sent record lost");

endmodule

// File: hdl/brace_balance_script_scanner.sv
`timescale 1ns / 1ps
// Brace-balance scanner for a script payload.
// Input channel (s_): one beat per payload byte. s_tdata carries the byte,
// s_tuser flags that the byte is real (clear it for an end-only beat), and
// s_tlast closes the payload. A beat with neither a byte nor tlast is ignored.
// Result channel (m_): m_tuser is the kind (0 repair event for a removed
// close brace, 1 final status); m_tdata holds line, column and status code;
// m_tlast marks the last result caused by one input beat. A beat causes at
// most two results: a repair and then the status on the closing beat.
// Throughput: one input beat per cycle while s_tready is high. The scanner
// updates its lexical state once per byte; the only limit is the result
// queue, which drains at one result per cycle while m_tready is high, so a
// closing beat that carries both a repair and a status leaves as two beats.
// Path: a result is written into the queue when its beat is taken, then moves
// from the queue into the output register that drives m_.
// Reset: aresetn (synchronous, active low) returns the scanner to the start
// of a payload and empties the queue. After each final status the scanner
// returns to that state on its own.
// Stall: when m_tready is low the output register holds, the queue fills and
// s_tready drops once it is full; no beat is lost or repeated.
module brace_balance_script_scanner #(
    parameter int unsigned MAX_NESTING = bbs_pkg::MAX_NESTING_DEF,
    parameter int unsigned QUEUE_DEPTH = bbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bbs_pkg::IN_DATA_BITS-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // [0] byte_present
    input  logic                              s_tlast,   // end_of_payload
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bbs_pkg::OUT_DATA_BITS-1:0] m_tdata,   // [19:0] line_number,
                                                         // [35:20] column_number,
                                                         // [38:36] status_code, [39] zero
    output logic                              m_tuser,   // [0] result_kind
    output logic                              m_tlast    // last_result
);

    logic          take;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    bbs_pkg::rec_t wr_rec;
    bbs_pkg::rec_t head;

    // accept a beat whenever the queue can take whatever it produces
    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    bbs_scan #(
        .MAX_NESTING (MAX_NESTING)
    ) u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .take           (take),
        .data_byte      (s_tdata),
        .byte_present   (s_tuser),
        .end_of_payload (s_tlast),
        .push           (push),
        .rec            (wr_rec)
    );

    bbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_rec  (wr_rec),
        .pop     (pop),
        .rd_rec  (head),
        .full    (full),
        .empty   (empty)
    );

    bbs_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: bench/brace_balance_script_scanner_test.sv
`timescale 1ns / 1ps
module brace_balance_script_scanner_test;

    localparam int unsigned RANDOM_BEATS = 320;
    localparam int unsigned LONG_HOLD    = 200;   // cycles the sink holds off under pressure

    // one result as the scanner should present it
    typedef struct packed {
        logic             kind;
        bbs_pkg::line_t   line_no;
        bbs_pkg::column_t col_no;
        bbs_pkg::status_t code;
        logic             last;
    } report_t;

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [bbs_pkg::IN_DATA_BITS-1:0]  s_tdata  = '0;     // [7:0] data_byte
    logic                              s_tuser  = 1'b0;   // [0] byte_present
    logic                              s_tlast  = 1'b0;   // end_of_payload
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [bbs_pkg::OUT_DATA_BITS-1:0] m_tdata;           // [19:0] line_number,
                                                          // [35:20] column_number,
                                                          // [38:36] status_code, [39] zero
    logic                              m_tuser;           // [0] result_kind
    logic                              m_tlast;           // last_result

    brace_balance_script_scanner DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the scanner state, advanced on every accepted beat.
    bbs_pkg::mode_t   scan_mode;
    logic             in_single_quote;
    logic             escape_next;
    logic             star_prev;
    logic             slash_prev;
    int unsigned      nest_level;
    bbs_pkg::line_t   cur_line;
    bbs_pkg::column_t cur_col;
    logic             line_blank;
    logic             brace_held;
    logic             brace_slash;
    bbs_pkg::column_t brace_col;
    bbs_pkg::status_t scan_error;
    // repair raised by the beat being predicted
    logic             repair_due;
    bbs_pkg::line_t   repair_line;
    bbs_pkg::column_t repair_col;

    report_t     expected_reports[$];
    logic [7:0]  script_q[$];

    int          mismatches       = 0;
    int          beats_sent       = 0;
    int          payloads_sent    = 0;
    int          repairs_checked  = 0;
    int          statuses_checked = 0;
    logic [7:0]  codes_seen       = '0;

    bit          src_idle_on  = 1'b0;
    bit          sink_idle_on = 1'b0;
    int          hold_requests = 0;
    int          holds_served  = 0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    function automatic bit is_blank_char(input logic [7:0] b);
        return b == bbs_pkg::CH_SPACE || b == bbs_pkg::CH_TAB || b == bbs_pkg::CH_CR;
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic clear_scanner();
        scan_mode       = bbs_pkg::MODE_NORMAL;
        in_single_quote = 1'b0;
        escape_next     = 1'b0;
        star_prev       = 1'b0;
        slash_prev      = 1'b0;
        nest_level      = 0;
        cur_line        = bbs_pkg::line_t'(1);
        cur_col         = '0;
        line_blank      = 1'b1;
        brace_held      = 1'b0;
        brace_slash     = 1'b0;
        brace_col       = '0;
        scan_error      = bbs_pkg::ST_SAFE;
    endtask

    task automatic confirm_brace();
        repair_due  = 1'b1;
        repair_line = cur_line;
        repair_col  = brace_col;
        brace_held  = 1'b0;
        brace_slash = 1'b0;
    endtask

    // Advance the shadow scanner by one payload byte.
    task automatic advance_scanner(input logic [7:0] b);
        logic             blank_prev;
        bbs_pkg::column_t here;
        // A lone close brace waits for its line to prove it stands alone.
        if (brace_held) begin
            if (brace_slash) begin
                if (b == bbs_pkg::CH_SLASH) begin
                    confirm_brace();
                    scan_mode  = bbs_pkg::MODE_LINE;
                    line_blank = 1'b0;
                    if (cur_col != '1) cur_col = cur_col + 1'b1;
                end else begin
                    scan_error = bbs_pkg::ST_SHARED;
                end
                return;
            end
            if (b == bbs_pkg::CH_SLASH) begin
                brace_slash = 1'b1;
                line_blank  = 1'b0;
                if (cur_col != '1) cur_col = cur_col + 1'b1;
                return;
            end
            if (b == bbs_pkg::CH_LF) begin
                confirm_brace();
            end else if (is_blank_char(b)) begin
                if (cur_col != '1) cur_col = cur_col + 1'b1;
                return;
            end else begin
                scan_error = bbs_pkg::ST_SHARED;
                return;
            end
        end

        if (b == bbs_pkg::CH_LF) begin
            if (cur_line != '1) cur_line = cur_line + 1'b1;
            cur_col     = '0;
            line_blank  = 1'b1;
            slash_prev  = 1'b0;
            star_prev   = 1'b0;
            escape_next = 1'b0;
            if (scan_mode == bbs_pkg::MODE_QUOTE) begin
                scan_error = bbs_pkg::ST_OPEN_QUOTE;
                return;
            end
            if (scan_mode == bbs_pkg::MODE_LINE) scan_mode = bbs_pkg::MODE_NORMAL;
            return;
        end

        if (cur_col != '1) cur_col = cur_col + 1'b1;
        here       = cur_col;
        blank_prev = line_blank;
        if (!is_blank_char(b)) line_blank = 1'b0;

        case (scan_mode)
            bbs_pkg::MODE_LINE: begin
                return;
            end
            bbs_pkg::MODE_BLOCK: begin
                if (star_prev && b == bbs_pkg::CH_SLASH) begin
                    scan_mode = bbs_pkg::MODE_NORMAL;
                    star_prev = 1'b0;
                end else begin
                    star_prev = (b == bbs_pkg::CH_STAR);
                end
                return;
            end
            bbs_pkg::MODE_QUOTE: begin
                if (escape_next) escape_next = 1'b0;
                else if (b == bbs_pkg::CH_BSLASH) escape_next = 1'b1;
                else if (b == (in_single_quote ? bbs_pkg::CH_SQUOTE : bbs_pkg::CH_DQUOTE))
                    scan_mode = bbs_pkg::MODE_NORMAL;
                return;
            end
            default: ;
        endcase

        if (slash_prev) begin
            slash_prev = 1'b0;
            if (b == bbs_pkg::CH_SLASH) begin
                scan_mode = bbs_pkg::MODE_LINE;
                return;
            end
            if (b == bbs_pkg::CH_STAR) begin
                scan_mode = bbs_pkg::MODE_BLOCK;
                star_prev = 1'b0;
                return;
            end
        end
        if (b == bbs_pkg::CH_SLASH) begin
            slash_prev = 1'b1;
            return;
        end
        if (b == bbs_pkg::CH_DQUOTE || b == bbs_pkg::CH_SQUOTE) begin
            scan_mode       = bbs_pkg::MODE_QUOTE;
            in_single_quote = (b == bbs_pkg::CH_SQUOTE);
            escape_next     = 1'b0;
            return;
        end
        if (b == bbs_pkg::CH_LBRACE) begin
            if (nest_level >= bbs_pkg::MAX_NESTING_DEF) scan_error = bbs_pkg::ST_TOO_DEEP;
            else nest_level++;
            return;
        end
        if (b != bbs_pkg::CH_RBRACE) return;
        if (nest_level != 0) begin
            nest_level--;
            return;
        end
        if (!blank_prev) begin
            scan_error = bbs_pkg::ST_SHARED;
            return;
        end
        brace_held  = 1'b1;
        brace_slash = 1'b0;
        brace_col   = here;
    endtask

    // Work out the results of one accepted beat and queue them.
    task automatic predict_beat(input logic [7:0] b, input logic present, input logic last);
        report_t r;
        repair_due = 1'b0;
        if (present && scan_error == bbs_pkg::ST_SAFE) advance_scanner(b);
        if (last) begin
            if (scan_error == bbs_pkg::ST_SAFE && brace_held) begin
                if (brace_slash) scan_error = bbs_pkg::ST_SHARED;
                else confirm_brace();
            end
            // open comment outranks open quote, which outranks open brace
            if (scan_error == bbs_pkg::ST_SAFE) begin
                if (scan_mode == bbs_pkg::MODE_BLOCK) scan_error = bbs_pkg::ST_OPEN_CMT;
                else if (scan_mode == bbs_pkg::MODE_QUOTE) scan_error = bbs_pkg::ST_OPEN_QUOTE;
                else if (nest_level != 0) scan_error = bbs_pkg::ST_OPEN_BRACE;
            end
        end
        if (repair_due) begin
            r.kind    = bbs_pkg::KIND_REPAIR;
            r.line_no = repair_line;
            r.col_no  = repair_col;
            r.code    = bbs_pkg::ST_SAFE;
            r.last    = !last;
            expected_reports.insert(expected_reports.size(), r);
        end
        if (last) begin
            r.kind    = bbs_pkg::KIND_STATUS;
            r.line_no = '0;
            r.col_no  = '0;
            r.code    = scan_error;
            r.last    = 1'b1;
            expected_reports.insert(expected_reports.size(), r);
            codes_seen[scan_error] = 1'b1;
            clear_scanner();
        end
    endtask

    // Offer one beat, hold it until the scanner takes it, then predict.
    // Valid stays high into the next beat unless that beat opens with a gap.
    task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
        int gap;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_beat(b, present, last);
        if (present || last) beats_sent++;
    endtask

    task automatic add_char(input logic [7:0] c);
        script_q.insert(script_q.size(), c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) script_q.insert(script_q.size(), s[i]);
    endtask

    task automatic add_blanks(input int max_len);
        int k;
        repeat ($urandom_range(max_len)) begin
            k = $urandom_range(2);
            add_char(k == 0 ? bbs_pkg::CH_SPACE : (k == 1 ? bbs_pkg::CH_TAB : bbs_pkg::CH_CR));
        end
    endtask

    task automatic add_word(input int max_len);
        repeat ($urandom_range(max_len)) add_char(8'($urandom_range(122, 97)));
    endtask

    function automatic logic [7:0] pick_special();
        case ($urandom_range(7))
            0: return bbs_pkg::CH_DQUOTE;
            1: return bbs_pkg::CH_SQUOTE;
            2: return bbs_pkg::CH_BSLASH;
            3: return bbs_pkg::CH_LBRACE;
            4: return bbs_pkg::CH_RBRACE;
            5: return bbs_pkg::CH_SLASH;
            6: return bbs_pkg::CH_STAR;
            default: return bbs_pkg::CH_SPACE;
        endcase
    endfunction

    // Send the buffered payload. Close it either on its last byte or with an
    // end-only beat; drop in the odd empty beat, which the scanner must ignore.
    task automatic send_payload(input bit end_only);
        int n;
        n = script_q.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(49) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
            send_beat(script_q[i], 1'b1, !end_only && i == n - 1);
        end
        if (end_only || n == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
        script_q.delete();
        payloads_sent++;
    endtask

    // Append one piece of script: mostly well-formed, some broken, some noise.
    task automatic add_fragment();
        int         n;
        logic [7:0] q;
        case ($urandom_range(13))
            0, 1, 2: begin
                // close brace alone on a fresh line, sometimes spoilt
                add_char(bbs_pkg::CH_LF);
                add_blanks(3);
                add_char(bbs_pkg::CH_RBRACE);
                add_blanks(2);
                n = $urandom_range(9);
                if (n < 4) begin
                    add_text("//");
                    add_word(4);
                end else if (n == 4) begin
                    add_char(bbs_pkg::CH_SLASH);
                    add_word(1);
                end else if (n == 5) begin
                    add_word(2);
                end
                add_char(bbs_pkg::CH_LF);
            end
            3, 4: begin
                add_char(bbs_pkg::CH_LBRACE);
                add_word(3);
                add_blanks(1);
                if ($urandom_range(9) != 0) add_char(bbs_pkg::CH_RBRACE);
            end
            5: begin
                q = $urandom_range(1) ? bbs_pkg::CH_SQUOTE : bbs_pkg::CH_DQUOTE;
                add_char(q);
                repeat ($urandom_range(6)) begin
                    n = $urandom_range(9);
                    if (n < 2) begin
                        add_char(bbs_pkg::CH_BSLASH);
                        add_char(pick_special());
                    end else if (n < 4) begin
                        add_char(pick_special());
                    end else begin
                        add_char(8'($urandom_range(122, 97)));
                    end
                end
                n = $urandom_range(19);
                if (n == 0) add_char(bbs_pkg::CH_LF);   // newline inside the quote
                else if (n > 1) add_char(q);            // one in twenty is left open
            end
            6: begin
                add_text("//");
                repeat ($urandom_range(5)) begin
                    if ($urandom_range(1)) add_char(pick_special());
                    else add_char(8'($urandom_range(122, 97)));
                end
                add_char(bbs_pkg::CH_LF);
            end
            7: begin
                add_text("/*");
                repeat ($urandom_range(8)) begin
                    n = $urandom_range(4);
                    if (n == 0) add_char(bbs_pkg::CH_STAR);
                    else if (n == 1) add_char(bbs_pkg::CH_LF);
                    else if (n == 2) add_char(pick_special());
                    else add_char(8'($urandom_range(122, 97)));
                end
                if ($urandom_range(9) != 0) add_text("*/");
            end
            8: begin
                // division: a slash that opens no comment
                add_word(2);
                add_blanks(1);
                add_char(bbs_pkg::CH_SLASH);
                add_blanks(1);
                add_word(2);
            end
            9: begin
                add_char(bbs_pkg::CH_LBRACE);
                add_char(bbs_pkg::CH_LF);
            end
            10: begin
                add_char(bbs_pkg::CH_RBRACE);
            end
            11: begin
                add_word(6);
                add_char(bbs_pkg::CH_LF);
            end
            12: begin
                add_char(8'($urandom_range(255)));
            end
            default: begin
                add_blanks(4);
            end
        endcase
    endtask

    // Short hand-written payloads: each final status but too deep, both ways of
    // closing a payload, the brace confirmed by end and by comment, byte extremes.
    task automatic test_directed_cases();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        add_text("\t}");      // confirmed by the end-only beat
        send_payload(1'b1);
        add_text("x}");       // brace shares its line
        send_payload(1'b0);
        add_text("} //c\n{"); // confirmed by a line comment, then an open brace left
        send_payload(1'b0);
        add_text("}/");       // half a comment after the brace at the end
        send_payload(1'b0);
        add_text("'\n");      // newline inside a quote
        send_payload(1'b1);
        add_text("/*");       // comment never closed
        send_payload(1'b0);
        add_text(" }");       // brace arriving on the closing beat itself
        send_payload(1'b0);
        send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
        add_char(8'h00);
        add_char(8'hFF);
        send_payload(1'b0);
    endtask

    // Open braces up to the nesting limit and one more, which latches too deep.
    task automatic test_nesting_limit();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (bbs_pkg::MAX_NESTING_DEF + 1) add_char(bbs_pkg::CH_LBRACE);
        send_payload(1'b1);
    endtask

    // Hold the sink off for a long stretch while lone braces keep coming, so
    // the result queue fills and the input side has to stall.
    task automatic test_backpressure();
        src_idle_on = 1'b0;
        hold_requests++;
        repeat (24) add_text("}\n");
        send_payload(1'b0);
    endtask

    task automatic test_random_scripts();
        int start;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            src_idle_on  = ($urandom_range(3) != 0);
            sink_idle_on = ($urandom_range(3) != 0);
            repeat ($urandom_range(8, 1)) add_fragment();
            send_payload(1'($urandom_range(1)));
        end
    endtask

    // Sink: random stalls, plus the long hold-off whenever one is requested.
    initial begin : sink_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left == 0) begin
                if (hold_requests != holds_served) begin
                    holds_served++;
                    stall_left = LONG_HOLD;
                end else begin
                    stall_left = pick_gap(sink_idle_on);
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge aclk) begin : result_check
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result with nothing expected", m_tdata, 0);
            end else begin
                want = expected_reports.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("result_kind", m_tuser, want.kind);
                if (m_tdata[19:0] !== want.line_no)
                    report_mismatch("line_number", m_tdata[19:0], want.line_no);
                if (m_tdata[35:20] !== want.col_no)
                    report_mismatch("column_number", m_tdata[35:20], want.col_no);
                if (m_tdata[38:36] !== want.code)
                    report_mismatch("status_code", m_tdata[38:36], want.code);
                if (m_tdata[39] !== 1'b0)
                    report_mismatch("tdata pad bit", m_tdata[39], 0);
                if (m_tlast !== want.last)
                    report_mismatch("last_result", m_tlast, want.last);
                if (want.kind == bbs_pkg::KIND_STATUS) statuses_checked++;
                else repairs_checked++;
            end
        end
    end

    initial begin
        clear_scanner();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_nesting_limit();
        test_backpressure();
        test_random_scripts();

        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Scanned %0d beats in %0d payloads; checked %0d brace repairs and %0d statuses.",
                 beats_sent, payloads_sent, repairs_checked, statuses_checked);
        $display("Final status codes reached (one bit per code, code 0 rightmost): %06b",
                 codes_seen[5:0]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #12_000_000;
        $display("Timed out with %0d results still expected", expected_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
